FILE: design/pre_pkg.sv
// shared types, constants and helpers for the polyline ribbon extrusion core
`default_nettype none

package pre_pkg;

  localparam int COORD_W = 32;
  localparam int DIR_W = 16;
  localparam int IDX_OUT_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_DATA_W = 3 * COORD_W;
  localparam int OUT_DATA_W = 5 * COORD_W + 3 * DIR_W;
  localparam int INDEX_BITS_DEFAULT = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_RIBBON_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_Z_OFFSET = 1'b1;

  localparam logic [CFG_W-1:0] RIBBON_WIDTH_RESET = 16'd300;
  localparam logic [CFG_W-1:0] Z_OFFSET_RESET = 16'd0;

  // 1.0 in Q1.15, saturated
  localparam logic [14:0] UNIT_MAG = 15'h7fff;

  // one vertex pair, packed so that left_x sits in the lowest bits
  typedef struct packed {
    logic        last_vertex_pair;
    logic [15:0] point_index;
    logic [15:0] dir_y;
    logic [15:0] dir_x;
    logic [31:0] vertex_z;
    logic [31:0] right_y;
    logic [31:0] right_x;
    logic [31:0] left_y;
    logic [31:0] left_x;
  } result_t;

  // clamp a 34-bit two's complement value to the 32-bit signed range
  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) begin
      r = 32'h7fff_ffff;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/pre_out_reg.sv
// output register stage holding one finished vertex pair
`default_nettype none

module pre_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire pre_pkg::result_t  load_data,
  output logic                   free,
  output logic                   valid,
  input  wire logic              ready,
  output pre_pkg::result_t       data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/polyline_ribbon_extrude_core.sv
// top level of the polyline ribbon extrusion core
`default_nettype none

// Takes one polyline point per transaction and emits ribbon vertex pairs one point late;
// the final point of a polyline yields two pairs and a single-point polyline yields none.
// One point is taken at a time. Each vertex pair is built on one shared datapath in order:
// normalizing shifts, multiplier passes for the squares, a bit-serial square root,
// restoring division for the unit direction, multiplier passes for the width offsets and
// a load of the output register, which waits while the previous pair is unread; a zero
// direction skips straight to the width offsets. The square root and the divider
// step one bit per cycle.
module polyline_ribbon_extrude_core #(
  parameter int INDEX_BITS = pre_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // point_x, point_y, ground_z
  input  wire logic [pre_pkg::IN_DATA_W-1:0]     s_tdata,
  // first_point
  input  wire logic                              s_tuser,
  // final_point
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // left_x, left_y, right_x, right_y, vertex_z, dir_x, dir_y, point_index
  output logic [pre_pkg::OUT_DATA_W-1:0]         m_tdata,
  // last_vertex_pair
  output logic                                   m_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [pre_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pre_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_START = 13'b0000000000010,
    ST_NORM  = 13'b0000000000100,
    ST_SQX   = 13'b0000000001000,
    ST_SQY   = 13'b0000000010000,
    ST_SUM   = 13'b0000000100000,
    ST_SQRT  = 13'b0000001000000,
    ST_DIVX  = 13'b0000010000000,
    ST_DIVY  = 13'b0000100000000,
    ST_OFFX  = 13'b0001000000000,
    ST_OFFY  = 13'b0010000000000,
    ST_OFFZ  = 13'b0100000000000,
    ST_EMIT  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [15:0] ribbon_width;
  logic [15:0] z_offset;

  logic [31:0] prev_x, prev_y, cur_x, cur_y, cur_z;
  logic [INDEX_BITS-1:0] pend_idx;
  logic holding;

  logic [31:0] in_x, in_y, in_z;
  logic in_first, in_final;

  logic [31:0] job_px, job_py, job_pz;
  logic [INDEX_BITS-1:0] job_idx;
  logic job_last, second_pending;

  logic sx, sy;
  logic [32:0] ax, ay;
  logic [61:0] prod;
  logic [63:0] sq_n, sq_r;
  logic [4:0] sq_cnt;
  logic [47:0] dv_rem, dv_trial;
  logic [15:0] dv_q;
  logic [3:0] dv_cnt;
  logic [14:0] cx, cy;
  logic [15:0] ox_mag, oy_mag;

  // direction setup
  logic [31:0] base_x, base_y;
  logic [32:0] dir_dx, dir_dy;
  logic [32:0] dx_abs, dy_abs;
  logic dir_zero;

  always_comb begin
    base_x = (state == ST_EMIT) ? cur_x : prev_x;
    base_y = (state == ST_EMIT) ? cur_y : prev_y;
    dir_dx = {in_x[31], in_x} - {base_x[31], base_x};
    dir_dy = {in_y[31], in_y} - {base_y[31], base_y};
    dx_abs = dir_dx[32] ? (33'd0 - dir_dx) : dir_dx;
    dy_abs = dir_dy[32] ? (33'd0 - dir_dy) : dir_dy;
    dir_zero = (dir_dx == 33'd0) && (dir_dy == 33'd0);
  end

  // normalizing shift
  logic [32:0] nrm_m;
  assign nrm_m = (ax > ay) ? ax : ay;

  // shared multiplier
  logic [30:0] mul_a, mul_b;
  always_comb begin
    case (state)
      ST_SQX: begin
        mul_a = ax[30:0];
        mul_b = ax[30:0];
      end
      ST_SQY: begin
        mul_a = ay[30:0];
        mul_b = ay[30:0];
      end
      ST_OFFX: begin
        mul_a = {16'd0, cy};
        mul_b = {15'd0, ribbon_width};
      end
      ST_OFFY: begin
        mul_a = {16'd0, cx};
        mul_b = {15'd0, ribbon_width};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic [31:0] off_rnd;
  assign off_rnd = prod[31:0] + 32'd32768;

  // square root step
  logic [63:0] sq_bit, sq_trial, sq_r_next, sq_n_next;
  logic [5:0] sq_pos;
  always_comb begin
    sq_pos = 6'd62 - {sq_cnt, 1'b0};
    sq_bit = 64'd1 << sq_pos;
    sq_trial = sq_r + sq_bit;
    if (sq_n >= sq_trial) begin
      sq_n_next = sq_n - sq_trial;
      sq_r_next = (sq_r >> 1) + sq_bit;
    end else begin
      sq_n_next = sq_n;
      sq_r_next = sq_r >> 1;
    end
  end

  // divider operands from the length
  logic [31:0] len_new, len_cur;
  logic [47:0] num_x, num_y;
  assign len_new = sq_r_next[31:0];
  assign len_cur = sq_r[31:0];
  assign num_x = {1'b0, ax[30:0], 16'd0} + {16'd0, len_new};
  assign num_y = {1'b0, ay[30:0], 16'd0} + {16'd0, len_cur};

  // restoring division step
  logic dv_bit;
  logic [47:0] dv_rem_next;
  logic [15:0] dv_q_next;
  logic [14:0] dv_sat;
  always_comb begin
    dv_bit = (dv_rem >= dv_trial);
    dv_rem_next = dv_bit ? (dv_rem - dv_trial) : dv_rem;
    dv_q_next = {dv_q[14:0], dv_bit};
    dv_sat = dv_q_next[15] ? pre_pkg::UNIT_MAG : dv_q_next[14:0];
  end

  function automatic logic [pre_pkg::IDX_OUT_W-1:0] IDX_OUT_CAST(
    input logic [INDEX_BITS-1:0] v);
    logic [pre_pkg::IDX_OUT_W+INDEX_BITS-1:0] w;
    w = {{pre_pkg::IDX_OUT_W{1'b0}}, v};
    return w[pre_pkg::IDX_OUT_W-1:0];
  endfunction

  // output assembly
  logic out_free, out_load;
  pre_pkg::result_t out_res, out_data;
  logic [33:0] px_w, py_w, pz_w, ox_s, oy_s, zo_w;

  always_comb begin
    px_w = {{2{job_px[31]}}, job_px};
    py_w = {{2{job_py[31]}}, job_py};
    pz_w = {{2{job_pz[31]}}, job_pz};
    zo_w = {{18{z_offset[15]}}, z_offset};
    ox_s = sy ? {18'd0, ox_mag} : (34'd0 - {18'd0, ox_mag});
    oy_s = sx ? (34'd0 - {18'd0, oy_mag}) : {18'd0, oy_mag};
    out_res.left_x = pre_pkg::sat32(px_w - ox_s);
    out_res.left_y = pre_pkg::sat32(py_w - oy_s);
    out_res.right_x = pre_pkg::sat32(px_w + ox_s);
    out_res.right_y = pre_pkg::sat32(py_w + oy_s);
    out_res.vertex_z = pre_pkg::sat32(pz_w + zo_w);
    out_res.dir_x = sx ? (16'd0 - {1'b0, cx}) : {1'b0, cx};
    out_res.dir_y = sy ? (16'd0 - {1'b0, cy}) : {1'b0, cy};
    out_res.point_index = IDX_OUT_CAST(job_idx);
    out_res.last_vertex_pair = job_last;
  end

  assign out_load = (state == ST_EMIT) && out_free;
  assign s_tready = (state == ST_IDLE);

  pre_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (out_res),
    .free      (out_free),
    .valid     (m_tvalid),
    .ready     (m_tready),
    .data      (out_data)
  );

  assign m_tdata = {out_data.point_index, out_data.dir_y, out_data.dir_x, out_data.vertex_z,
                    out_data.right_y, out_data.right_x, out_data.left_y, out_data.left_x};
  assign m_tlast = out_data.last_vertex_pair;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ribbon_width <= pre_pkg::RIBBON_WIDTH_RESET;
      z_offset <= pre_pkg::Z_OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pre_pkg::REG_RIBBON_WIDTH: ribbon_width <= cfg_data;
        pre_pkg::REG_Z_OFFSET:     z_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and polyline state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      prev_x <= '0;
      prev_y <= '0;
      cur_x <= '0;
      cur_y <= '0;
      cur_z <= '0;
      pend_idx <= '0;
      holding <= 1'b0;
      second_pending <= 1'b0;
    end else begin
      prod <= mul_a * mul_b;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_x <= s_tdata[31:0];
            in_y <= s_tdata[63:32];
            in_z <= s_tdata[95:64];
            in_first <= s_tuser;
            in_final <= s_tlast;
            state <= ST_START;
          end
        end
        ST_START: begin
          if (in_first || !holding) begin
            prev_x <= in_x;
            prev_y <= in_y;
            cur_x <= in_x;
            cur_y <= in_y;
            cur_z <= in_z;
            pend_idx <= '0;
            holding <= !in_final;
            state <= ST_IDLE;
          end else begin
            job_px <= cur_x;
            job_py <= cur_y;
            job_pz <= cur_z;
            job_idx <= pend_idx;
            job_last <= 1'b0;
            second_pending <= in_final;
            if (in_final) begin
              holding <= 1'b0;
            end else begin
              prev_x <= cur_x;
              prev_y <= cur_y;
              cur_x <= in_x;
              cur_y <= in_y;
              cur_z <= in_z;
              pend_idx <= pend_idx + 1'b1;
            end
            ax <= dx_abs;
            ay <= dy_abs;
            if (dir_zero) begin
              sx <= 1'b0;
              sy <= 1'b0;
              cx <= pre_pkg::UNIT_MAG;
              cy <= '0;
              state <= ST_OFFX;
            end else begin
              sx <= dir_dx[32];
              sy <= dir_dy[32];
              state <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (nrm_m[32:31] != 2'b00) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
          end else if (nrm_m[30:26] == 5'd0) begin
            ax <= ax << 4;
            ay <= ay << 4;
          end else if (!nrm_m[30]) begin
            ax <= ax << 1;
            ay <= ay << 1;
          end else begin
            state <= ST_SQX;
          end
        end
        ST_SQX: begin
          state <= ST_SQY;
        end
        ST_SQY: begin
          sq_n <= {2'b00, prod};
          state <= ST_SUM;
        end
        ST_SUM: begin
          sq_n <= sq_n + {2'b00, prod};
          sq_r <= '0;
          sq_cnt <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          sq_n <= sq_n_next;
          sq_r <= sq_r_next;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd31) begin
            dv_rem <= num_x;
            dv_trial <= {len_new, 16'd0};
            dv_q <= '0;
            dv_cnt <= 4'd15;
            state <= ST_DIVX;
          end
        end
        ST_DIVX: begin
          if (dv_cnt == 4'd0) begin
            cx <= dv_sat;
            dv_rem <= num_y;
            dv_trial <= {len_cur, 16'd0};
            dv_q <= '0;
            dv_cnt <= 4'd15;
            state <= ST_DIVY;
          end else begin
            dv_rem <= dv_rem_next;
            dv_trial <= dv_trial >> 1;
            dv_q <= dv_q_next;
            dv_cnt <= dv_cnt - 1'b1;
          end
        end
        ST_DIVY: begin
          dv_rem <= dv_rem_next;
          dv_trial <= dv_trial >> 1;
          dv_q <= dv_q_next;
          dv_cnt <= dv_cnt - 1'b1;
          if (dv_cnt == 4'd0) begin
            cy <= dv_sat;
            state <= ST_OFFX;
          end
        end
        ST_OFFX: begin
          state <= ST_OFFY;
        end
        ST_OFFY: begin
          ox_mag <= off_rnd[31:16];
          state <= ST_OFFZ;
        end
        ST_OFFZ: begin
          oy_mag <= off_rnd[31:16];
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (second_pending) begin
              job_px <= in_x;
              job_py <= in_y;
              job_pz <= in_z;
              job_idx <= pend_idx + 1'b1;
              job_last <= 1'b1;
              second_pending <= 1'b0;
              ax <= dx_abs;
              ay <= dy_abs;
              if (dir_zero) begin
                sx <= 1'b0;
                sy <= 1'b0;
                cx <= pre_pkg::UNIT_MAG;
                cy <= '0;
                state <= ST_OFFX;
              end else begin
                sx <= dir_dx[32];
                sy <= dir_dy[32];
                state <= ST_NORM;
              end
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_one_point_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a point is in flight");

  a_idle_no_pending_pair: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !second_pending)
    else $error("ready with a final vertex pair still owed");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) && (sq_cnt == 5'd0) |-> (sq_n[63:60] != 4'd0) && !sq_n[63])
    else $error("sum of squares outside normalized range");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVX) && (dv_cnt == 4'd15) |->
      (sq_r[63:32] == 32'd0) && (sq_r[31:30] != 2'b00))
    else $error("length outside normalized range");

endmodule

`default_nettype wire
